/* src/length_prefix_deframer_macros.svh */
// Assertion macros for the length-prefix deframer.
`ifndef LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_MACROS_SVH

`ifndef SYNTH
`define LPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
`define LPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define LPD_ASSERT_IMP(label, ante, cons)
`define LPD_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* src/lpd_pkg.sv */
// Shared constants and types of the length-prefix deframer.
package lpd_pkg;

  localparam int MAX_FRAME_BYTES = 1048576;
  localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CFG_W           = 21;
  localparam int CFG_IDX_W       = 2;
  localparam int Q_DEPTH         = 8;
  localparam int Q_AW            = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_HDR_FOUR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_COUNTED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

  typedef struct packed {
    logic             hdr_four;
    logic             hdr_counted;
    logic [CFG_W-1:0] max_len;
  } lpd_cfg_t;

  // One queued record: up to four bytes, left aligned, sent high byte first.
  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  nb;
    logic        last;
    logic        err;
    logic [31:0] seq;
  } lpd_rec_t;

  typedef struct packed {
    logic in_error;
  } lpd_par_stat_t;

  typedef struct packed {
    logic full;
  } lpd_q_stat_t;

endpackage

/* src/lpd_in_if.sv */
// Byte stream channel into the deframer.
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* src/lpd_out_if.sv */
// Message byte channel out of the deframer.
interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_byte;
  logic        msg_last;
  logic [31:0] msg_seq;
  logic        frame_error;

  modport source (output valid, output msg_byte, output msg_last, output msg_seq,
                  output frame_error, input ready);
  modport sink (input valid, input msg_byte, input msg_last, input msg_seq,
                input frame_error, output ready);
endinterface

/* src/lpd_parser.sv */
// Header collection, length check and body tracking; emits at most one record per request.
module lpd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lpd_pkg::lpd_cfg_t     cfg,
  input  logic                  in_fire,
  input  logic [7:0]            in_byte,
  output logic                  rec_push,
  output lpd_pkg::lpd_rec_t     rec,
  output lpd_pkg::lpd_par_stat_t stat
);
  import lpd_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;
  localparam logic [31:0] MAX_FRAME_W = 32'(MAX_FRAME_BYTES);

  logic [1:0]       phase_r, phase_nxt;
  logic [1:0]       hcnt_r, hcnt_nxt;
  logic [7:0]       hold_r [4];
  logic [7:0]       hold_w [4];
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [31:0]      seq_r, seq_nxt;

  logic [2:0]  hsize;
  logic [2:0]  cnt_inc;
  logic [31:0] len;
  logic [31:0] limit;
  logic [32:0] len_x, hs_x, lim_x;
  logic        bad;

  always_comb begin
    hsize   = cfg.hdr_four ? 3'd4 : 3'd2;
    cnt_inc = {1'b0, hcnt_r} + 3'd1;
    hold_w  = hold_r;
    hold_w[hcnt_r] = in_byte;
    len = cfg.hdr_four ? {hold_w[0], hold_w[1], hold_w[2], hold_w[3]}
                       : {16'd0, hold_w[0], hold_w[1]};
    limit = ({11'd0, cfg.max_len} > MAX_FRAME_W) ? MAX_FRAME_W : {11'd0, cfg.max_len};
    len_x = {1'b0, len};
    hs_x  = {30'd0, hsize};
    lim_x = {1'b0, limit};
    bad   = (len_x <= hs_x) || (len_x > lim_x) ||
            (!cfg.hdr_counted && ((len_x + hs_x) > lim_x));
  end

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    left_nxt  = left_r;
    seq_nxt   = seq_r;
    rec_push  = 1'b0;
    rec       = '0;
    rec.seq   = seq_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          hcnt_nxt = cnt_inc[1:0];
          if (cnt_inc >= hsize) begin
            hcnt_nxt = 2'd0;
            if (bad) begin
              phase_nxt = PH_ERROR;
              rec_push  = 1'b1;
              rec.err   = 1'b1;
            end else begin
              phase_nxt = PH_BODY;
              if (cfg.hdr_counted) begin
                rec_push = 1'b1;
                rec.data = cfg.hdr_four ? {hold_w[0], hold_w[1], hold_w[2], hold_w[3]}
                                        : {hold_w[0], hold_w[1], 16'd0};
                rec.nb   = 2'(hsize - 3'd1);
                left_nxt = LEN_W'(len - {29'd0, hsize});
              end else begin
                left_nxt = LEN_W'(len);
              end
            end
          end
        end
        PH_BODY: begin
          rec_push = 1'b1;
          rec.data = {in_byte, 24'd0};
          if (left_r <= LEN_W'(1)) begin
            rec.last  = 1'b1;
            left_nxt  = '0;
            seq_nxt   = seq_r + 32'd1;
            phase_nxt = PH_HEADER;
          end else begin
            left_nxt = left_r - LEN_W'(1);
          end
        end
        PH_ERROR: begin
          phase_nxt = PH_ERROR;
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= 2'd0;
      left_r  <= '0;
      seq_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      left_r  <= left_nxt;
      seq_r   <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (phase_r == PH_HEADER)) begin
      hold_r <= hold_w;
    end
  end

  assign stat.in_error = (phase_r == PH_ERROR);

endmodule

/* src/lpd_out_queue.sv */
// Record queue and output register that sends each record one byte at a time.
module lpd_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lpd_pkg::lpd_rec_t    rec_in,
  output lpd_pkg::lpd_q_stat_t stat,
  lpd_out_if.source            out_ch
);
  import lpd_pkg::*;

  lpd_rec_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  logic        ovalid_r;
  logic [31:0] odata_r;
  logic [1:0]  oleft_r;
  logic        olast_r, oerr_r;
  logic [31:0] oseq_r;

  logic     empty, taken, pop;
  lpd_rec_t head;

  assign empty = (cnt_r == '0);
  assign stat.full = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign taken = ovalid_r && out_ch.ready;
  assign pop   = !empty && (!ovalid_r || (taken && (oleft_r == 2'd0)));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      cnt_r <= cnt_r + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
      if (pop) begin
        ovalid_r <= 1'b1;
      end else if (taken && (oleft_r == 2'd0)) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      odata_r <= head.data;
      oleft_r <= head.nb;
      olast_r <= head.last;
      oerr_r  <= head.err;
      oseq_r  <= head.seq;
    end else if (taken && (oleft_r != 2'd0)) begin
      odata_r <= {odata_r[23:0], 8'd0};
      oleft_r <= oleft_r - 2'd1;
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.msg_byte    = odata_r[31:24];
  assign out_ch.msg_last    = olast_r;
  assign out_ch.msg_seq     = oseq_r;
  assign out_ch.frame_error = oerr_r;

endmodule

/* src/length_prefix_deframer.sv */
// Top level of the length-prefix deframer.
//
// in_ch carries the received stream, one byte per request. Each message opens
// with a big-endian length header of two or four bytes (cfg register 0).
// Text mode strips the header; binary mode (cfg register 1) counts it in the
// length and sends it out once the length passes the check against
// cfg register 2 and the build limit. out_ch carries one byte per request
// with its message number, a last mark and the error flag.
// A byte is taken every cycle while the eight-record queue has room; the
// first result of a request is queued, then loaded into the output register. A
// binary header leaves as a burst of two or four bytes, one per cycle while
// out_ch is ready, which the queue absorbs since header bytes themselves give
// no result. A stalled receiver holds the output register; the queue keeps
// taking bytes until it fills, then in_ch.ready drops. A bad length gives one
// error result and drops all later bytes until reset. Reset empties the queue,
// restores the registers (four-byte header, text mode, 65536-byte limit) and
// starts at a header with message number zero. Write cfg only when idle.
`include "length_prefix_deframer_macros.svh"

module length_prefix_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  lpd_in_if.sink                         in_ch,
  lpd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpd_pkg::CFG_W-1:0]      cfg_wdata
);
  import lpd_pkg::*;

  lpd_cfg_t      cfg_r;
  lpd_rec_t      rec;
  logic          rec_push;
  logic          in_fire;
  lpd_par_stat_t par_stat;
  lpd_q_stat_t   q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_four    <= 1'b1;
      cfg_r.hdr_counted <= 1'b0;
      cfg_r.max_len     <= CFG_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HDR_FOUR:    cfg_r.hdr_four    <= cfg_wdata[0];
        CFG_HDR_COUNTED: cfg_r.hdr_counted <= cfg_wdata[0];
        CFG_MAX_LEN:     cfg_r.max_len     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !q_stat.full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  lpd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_fire  (in_fire),
    .in_byte  (in_ch.rx_byte),
    .rec_push (rec_push),
    .rec      (rec),
    .stat     (par_stat)
  );

  lpd_out_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (rec_push),
    .rec_in (rec),
    .stat   (q_stat),
    .out_ch (out_ch)
  );

  `LPD_ASSERT_NXT(a_error_sticky, par_stat.in_error, par_stat.in_error)
  `LPD_ASSERT_IMP(a_error_result_zero, out_ch.valid && out_ch.frame_error, (out_ch.msg_byte == 8'd0) && !out_ch.msg_last)
  `LPD_ASSERT_IMP(a_stall_only_full, !in_ch.ready, q_stat.full)
  `LPD_ASSERT_IMP(a_no_push_after_error, par_stat.in_error, !rec_push)

endmodule
